// ===== design/fragment_reassembler_crc16_assert.svh =====
// Assertion macros shared by the reassembler RTL.
// Both forms expect clock and reset to be visible in the enclosing module.
`ifndef FRAGMENT_REASSEMBLER_CRC16_ASSERT_SVH
`define FRAGMENT_REASSEMBLER_CRC16_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FRC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FRC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/frc_pkg.sv =====
package frc_pkg;

   // Largest message the store holds by default
   localparam int MSG_MAX_DEF = 64;

   // Byte counts and message lengths; holds up to the largest MSG_MAX plus one
   localparam int LEN_W = 7;

   localparam int HDR_BYTES = 6;
   localparam int CRC_BYTES = 2;
   localparam int MIN_FRAME = HDR_BYTES + CRC_BYTES;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // Sequence counter stops here; no 4-bit sequence number matches it
   localparam logic [4:0] SEQ_LIMIT = 5'd16;

   // Header byte positions within a fragment
   localparam logic [LEN_W-1:0] IDX_TYPE_HI = LEN_W'(0);
   localparam logic [LEN_W-1:0] IDX_TYPE_LO = LEN_W'(1);
   localparam logic [LEN_W-1:0] IDX_FLAGS   = LEN_W'(2);
   localparam logic [LEN_W-1:0] IDX_IDENT   = LEN_W'(3);
   localparam logic [LEN_W-1:0] IDX_PLEN_HI = LEN_W'(4);
   localparam logic [LEN_W-1:0] IDX_PLEN_LO = LEN_W'(5);

   localparam logic [2:0] MORE_POS_RESET = 3'd4;

   typedef enum logic [2:0] {
      STAT_TAKEN = 3'd0,
      STAT_DONE  = 3'd1,
      STAT_CRC   = 3'd2,
      STAT_LEN   = 3'd3,
      STAT_SEQ   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RESP,
      ST_EMIT
   } state_type;

   // Per-fragment front-end state seen by the message logic
   typedef struct packed {
      logic [15:0]      crc;
      logic [7:0]       dly1;
      logic [7:0]       dly0;
      logic [LEN_W-1:0] count;
      logic [15:0]      hdr_type;
      logic [7:0]       hdr_flags;
      logic [7:0]       hdr_ident;
      logic [15:0]      hdr_plen;
   } frame_info_type;

   // CRC-16/CCITT-FALSE, one byte MSB first
   function automatic logic [15:0] crc_absorb(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ===== design/frc_ram.sv =====
module frc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/frc_frame.sv =====
module frc_frame import frc_pkg::*; #(
   parameter int MSG_MAX = MSG_MAX_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           byte_en,
   input  logic [7:0]     frag_byte,
   input  logic           frame_clear,
   output frame_info_type info
);

   localparam logic [LEN_W-1:0] MAX_CNT = LEN_W'(MSG_MAX);
   localparam logic [LEN_W-1:0] CRC_START = LEN_W'(CRC_BYTES);

   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       dly1_ff, dly1_in;
   logic [7:0]       dly0_ff, dly0_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic [15:0]      hdr_type_ff, hdr_type_in;
   logic [7:0]       hdr_flags_ff, hdr_flags_in;
   logic [7:0]       hdr_ident_ff, hdr_ident_in;
   logic [15:0]      hdr_plen_ff, hdr_plen_in;

   // Absorb the byte two behind, shift the delay line, capture header fields
   always_comb begin
      crc_in       = crc_ff;
      dly1_in      = dly1_ff;
      dly0_in      = dly0_ff;
      count_in     = count_ff;
      hdr_type_in  = hdr_type_ff;
      hdr_flags_in = hdr_flags_ff;
      hdr_ident_in = hdr_ident_ff;
      hdr_plen_in  = hdr_plen_ff;
      if (frame_clear) begin
         crc_in   = CRC_INIT;
         dly1_in  = 8'h00;
         dly0_in  = 8'h00;
         count_in = '0;
      end else if (byte_en) begin
         if (count_ff >= CRC_START) begin
            crc_in = crc_absorb(crc_ff, dly1_ff);
         end
         dly1_in = dly0_ff;
         dly0_in = frag_byte;
         unique case (count_ff)
            IDX_TYPE_HI: hdr_type_in  = {frag_byte, 8'h00};
            IDX_TYPE_LO: hdr_type_in  = {hdr_type_ff[15:8], frag_byte};
            IDX_FLAGS:   hdr_flags_in = frag_byte;
            IDX_IDENT:   hdr_ident_in = frag_byte;
            IDX_PLEN_HI: hdr_plen_in  = {frag_byte, 8'h00};
            IDX_PLEN_LO: hdr_plen_in  = {hdr_plen_ff[15:8], frag_byte};
            default: begin
            end
         endcase
         // saturate one past the limit
         if (count_ff <= MAX_CNT) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         dly1_ff      <= 8'h00;
         dly0_ff      <= 8'h00;
         count_ff     <= '0;
         hdr_type_ff  <= 16'h0000;
         hdr_flags_ff <= 8'h00;
         hdr_ident_ff <= 8'h00;
         hdr_plen_ff  <= 16'h0000;
      end else begin
         crc_ff       <= crc_in;
         dly1_ff      <= dly1_in;
         dly0_ff      <= dly0_in;
         count_ff     <= count_in;
         hdr_type_ff  <= hdr_type_in;
         hdr_flags_ff <= hdr_flags_in;
         hdr_ident_ff <= hdr_ident_in;
         hdr_plen_ff  <= hdr_plen_in;
      end
   end

   always_comb begin
      info.crc       = crc_ff;
      info.dly1      = dly1_ff;
      info.dly0      = dly0_ff;
      info.count     = count_ff;
      info.hdr_type  = hdr_type_ff;
      info.hdr_flags = hdr_flags_ff;
      info.hdr_ident = hdr_ident_ff;
      info.hdr_plen  = hdr_plen_ff;
   end

endmodule

// ===== design/fragment_reassembler_crc16.sv =====
// Takes one fragment byte per cycle; a byte without the last flag gives no beat.
// After the last byte, the check state tests the fragment and the first result beat shows
// in the state after it; a message then streams one payload beat per cycle, unless the
// output stalls, from the single-port-read message RAM. Input stalls from the last byte
// until the final beat is taken.
// Synchronous active-high reset clears control and counters; the message RAM is not cleared.
`include "fragment_reassembler_crc16_assert.svh"

module fragment_reassembler_crc16 import frc_pkg::*; #(
   parameter int MSG_MAX = MSG_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_frag_byte,
   input  logic        req_frag_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_msg_type,
   output logic [7:0]  rsp_msg_ident,
   output logic [6:0]  rsp_msg_length,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_data_final,
   output logic [31:0] rsp_crc_error_count,
   output logic [31:0] rsp_parse_error_count,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_write_data
);

   localparam int ADDR_W = $clog2(MSG_MAX);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MSG_MAX);
   localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(MIN_FRAME);
   localparam logic [LEN_W-1:0] HDR_LEN = LEN_W'(HDR_BYTES);

   state_type        state_ff, state_in;
   logic [2:0]       more_pos_ff, more_pos_in;
   logic [LEN_W-1:0] message_len_ff, message_len_in;
   logic [4:0]       expected_seq_ff, expected_seq_in;
   logic             active_ff, active_in;
   logic [15:0]      held_type_ff, held_type_in;
   logic [7:0]       held_ident_ff, held_ident_in;
   logic [31:0]      crc_errors_ff, crc_errors_in;
   logic [31:0]      parse_errors_ff, parse_errors_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0] emit_idx_ff, emit_idx_in;

   logic             req_accept;
   logic             rsp_accept;
   logic             frame_clear;
   frame_info_type   fi;

   logic             wr_en;
   logic [LEN_W-1:0] wr_base;
   logic [LEN_W:0]   wr_sum;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]       rd_data;

   status_type       ck_status;
   logic             ck_start;
   logic             ck_cont;
   logic             ck_more;
   logic             ck_single;
   logic [LEN_W-1:0] ck_len_next;
   logic [LEN_W-1:0] room;
   logic             last_beat;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign frame_clear = (state_ff == ST_CHECK);

   frc_frame #(
      .MSG_MAX(MSG_MAX)
   ) u_frame (
      .clock      (clock),
      .reset      (reset),
      .byte_en    (req_accept),
      .frag_byte  (req_frag_byte),
      .frame_clear(frame_clear),
      .info       (fi)
   );

   // Stage payload bytes into the store as they arrive
   always_comb begin
      wr_base = (fi.hdr_flags[3:0] == 4'd0) ? '0 : message_len_ff;
      wr_sum  = {1'b0, wr_base} + {1'b0, fi.count} - {1'b0, HDR_LEN};
      wr_en   = req_accept && (fi.count >= HDR_LEN) && (fi.count < MAX_LEN)
                && (wr_sum < {1'b0, MAX_LEN});
   end

   // Zero the address in ST_CHECK, hold it while a beat stalls, step it when the beat goes
   always_comb begin
      if (state_ff == ST_CHECK) begin
         rd_addr = '0;
      end else if (state_ff == ST_EMIT && rsp_accept) begin
         rd_addr = emit_idx_ff + 1'b1;
      end else begin
         rd_addr = emit_idx_ff;
      end
   end

   frc_ram #(
      .WIDTH(8),
      .DEPTH(MSG_MAX)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_sum[ADDR_W-1:0]),
      .wr_data(req_frag_byte),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Check the finished fragment: length, CRC, length field, then sequence
   always_comb begin
      room      = MAX_LEN - message_len_ff;
      ck_more   = fi.hdr_flags[more_pos_ff];
      ck_start  = 1'b0;
      ck_cont   = 1'b0;
      ck_status = STAT_TAKEN;
      if (fi.count > MAX_LEN || fi.count < MIN_LEN) begin
         ck_status = STAT_LEN;
      end else if (fi.crc != {fi.dly1, fi.dly0}) begin
         ck_status = STAT_CRC;
      end else if (fi.hdr_plen != (16'(fi.count) - 16'(MIN_FRAME))) begin
         ck_status = STAT_LEN;
      end else if (fi.hdr_flags[3:0] == 4'd0) begin
         ck_start = 1'b1;
      end else if (active_ff && ({1'b0, fi.hdr_flags[3:0]} == expected_seq_ff)
                   && fi.hdr_type == held_type_ff && fi.hdr_ident == held_ident_ff
                   && fi.hdr_plen <= 16'(room)) begin
         ck_cont = 1'b1;
      end else begin
         ck_status = STAT_SEQ;
      end
      if (ck_start) begin
         ck_len_next = fi.hdr_plen[LEN_W-1:0];
      end else if (ck_cont) begin
         ck_len_next = message_len_ff + fi.hdr_plen[LEN_W-1:0];
      end else begin
         ck_len_next = message_len_ff;
      end
      ck_single = (ck_status != STAT_TAKEN) || ck_more || (ck_len_next == '0);
   end

   assign last_beat = ((LEN_W'(emit_idx_ff) + 1'b1) == message_len_ff);

   // Message state, error counters and result bookkeeping
   always_comb begin
      more_pos_in     = more_pos_ff;
      message_len_in  = message_len_ff;
      expected_seq_in = expected_seq_ff;
      active_in       = active_ff;
      held_type_in    = held_type_ff;
      held_ident_in   = held_ident_ff;
      crc_errors_in   = crc_errors_ff;
      parse_errors_in = parse_errors_ff;
      rsp_status_in   = rsp_status_ff;
      emit_idx_in     = emit_idx_ff;
      if (csr_write_enable) begin
         more_pos_in = csr_write_data;
      end
      if (state_ff == ST_CHECK) begin
         message_len_in = ck_len_next;
         emit_idx_in    = '0;
         if (ck_start) begin
            held_type_in    = fi.hdr_type;
            held_ident_in   = fi.hdr_ident;
            expected_seq_in = 5'd1;
            active_in       = 1'b1;
         end
         if (ck_cont && expected_seq_ff < SEQ_LIMIT) begin
            expected_seq_in = expected_seq_ff + 1'b1;
         end
         case (ck_status) inside
            STAT_CRC: begin
               crc_errors_in = crc_errors_ff + 32'd1;
               active_in     = 1'b0;
            end
            STAT_LEN, STAT_SEQ: begin
               parse_errors_in = parse_errors_ff + 32'd1;
               active_in       = 1'b0;
            end
            default: begin
            end
         endcase
         // a good fragment without the more flag completes the message
         if (ck_status == STAT_TAKEN && !ck_more) begin
            active_in     = 1'b0;
            rsp_status_in = STAT_DONE;
         end else begin
            rsp_status_in = ck_status;
         end
      end
      if (state_ff == ST_EMIT && rsp_accept) begin
         emit_idx_in = emit_idx_ff + 1'b1;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_frag_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = ck_single ? ST_RESP : ST_EMIT;
         end
         ST_RESP: begin
            if (rsp_accept) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_accept && last_beat) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake and result beat
   always_comb begin
      req_stall      = (state_ff != ST_IDLE);
      rsp_valid      = (state_ff == ST_RESP) || (state_ff == ST_EMIT);
      rsp_status     = rsp_status_ff;
      rsp_msg_type   = 16'h0000;
      rsp_msg_ident  = 8'h00;
      rsp_msg_length = 7'd0;
      rsp_data_byte  = 8'h00;
      rsp_data_final = 1'b1;
      if (rsp_status_ff == STAT_DONE) begin
         rsp_msg_type   = held_type_ff;
         rsp_msg_ident  = held_ident_ff;
         rsp_msg_length = 7'(message_len_ff);
      end
      if (state_ff == ST_EMIT) begin
         rsp_data_byte  = rd_data;
         rsp_data_final = last_beat;
      end
      rsp_crc_error_count   = crc_errors_ff;
      rsp_parse_error_count = parse_errors_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         more_pos_ff     <= MORE_POS_RESET;
         message_len_ff  <= '0;
         expected_seq_ff <= 5'd0;
         active_ff       <= 1'b0;
         held_type_ff    <= 16'h0000;
         held_ident_ff   <= 8'h00;
         crc_errors_ff   <= 32'd0;
         parse_errors_ff <= 32'd0;
         rsp_status_ff   <= STAT_TAKEN;
         emit_idx_ff     <= '0;
      end else begin
         state_ff        <= state_in;
         more_pos_ff     <= more_pos_in;
         message_len_ff  <= message_len_in;
         expected_seq_ff <= expected_seq_in;
         active_ff       <= active_in;
         held_type_ff    <= held_type_in;
         held_ident_ff   <= held_ident_in;
         crc_errors_ff   <= crc_errors_in;
         parse_errors_ff <= parse_errors_in;
         rsp_status_ff   <= rsp_status_in;
         emit_idx_ff     <= emit_idx_in;
      end
   end

   `FRC_ASSERT_NEXT(a_last_starts_check, req_accept && req_frag_last, state_ff == ST_CHECK, "last beat did not start the fragment check")
   `FRC_ASSERT_NOW(a_emit_in_range, state_ff == ST_EMIT, (LEN_W'(emit_idx_ff) < message_len_ff), "emit index past message length")
   `FRC_ASSERT_NOW(a_emit_closed, state_ff == ST_EMIT, rsp_status_ff == STAT_DONE && !active_ff, "emitting a message that is still open")
   `FRC_ASSERT_NEXT(a_crc_counted, state_ff == ST_CHECK && ck_status == STAT_CRC, crc_errors_ff == $past(crc_errors_ff) + 32'd1, "crc error not counted")

endmodule

// ===== verif/fragment_reassembler_crc16_tb.sv =====
module fragment_reassembler_crc16_tb;
   import frc_pkg::*;

   localparam int MSG_MAX = MSG_MAX_DEF;
   localparam int QUIET_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 6;
   localparam int PHASE_BYTES = 16;

   // Ways a fragment is damaged on purpose
   typedef enum logic [2:0] {
      F_NONE  = 3'd0,
      F_CRC   = 3'd1,
      F_PLEN  = 3'd2,
      F_SHORT = 3'd3,
      F_NOISE = 3'd4,
      F_SEQ   = 3'd5,
      F_TYPE  = 3'd6,
      F_IDENT = 3'd7
   } fault_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] msg_type;
      logic [7:0]  msg_ident;
      logic [6:0]  msg_length;
      logic [7:0]  data_byte;
      logic        data_final;
      logic [31:0] crc_errs;
      logic [31:0] parse_errs;
      logic        has_table;
      status_type  table_status;
   } beat_type;

   // One directed fragment; runs repeats it with the sequence field counting up
   typedef struct packed {
      logic [2:0]  more_pos;
      logic [15:0] ftype;
      logic [7:0]  flags;
      logic [7:0]  ident;
      logic [6:0]  pay_len;
      logic [4:0]  runs;
      fault_type   fault;
      logic        checked;
      status_type  exp_status;
   } directed_row_type;

   localparam int NUM_ROWS = 8;
   // rows of the store-filling message run with no idling on either side
   localparam int STEADY_ROW = 5;
   localparam directed_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      // empty message right after reset
      '{3'd4, 16'h0000, 8'h00, 8'h00, 7'd0,  5'd1,  F_NONE,  1'b1, STAT_DONE},
      // too long, lone byte, bad crc, bad length field
      '{3'd4, 16'h1234, 8'h00, 8'h01, 7'd57, 5'd1,  F_NONE,  1'b1, STAT_LEN},
      '{3'd4, 16'h1234, 8'h00, 8'h01, 7'd1,  5'd1,  F_SHORT, 1'b1, STAT_LEN},
      '{3'd4, 16'h1234, 8'h00, 8'h01, 7'd0,  5'd1,  F_CRC,   1'b1, STAT_CRC},
      '{3'd4, 16'h1234, 8'h00, 8'h01, 7'd0,  5'd1,  F_PLEN,  1'b1, STAT_LEN},
      // largest fragment, then a continuation that fills the store exactly
      '{3'd4, 16'hABCD, 8'h10, 8'h5A, 7'd56, 5'd1,  F_NONE,  1'b1, STAT_TAKEN},
      '{3'd4, 16'hABCD, 8'h01, 8'h5A, 7'd8,  5'd1,  F_NONE,  1'b1, STAT_DONE},
      // continuation with no open message
      '{3'd4, 16'hABCD, 8'h01, 8'h5A, 7'd0,  5'd1,  F_NONE,  1'b1, STAT_SEQ}
   };

   localparam logic [2:0] RANDOM_POSITIONS [2] = '{3'd7, 3'd0};

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_frag_byte;
   logic        req_frag_last;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_msg_type;
   logic [7:0]  rsp_msg_ident;
   logic [6:0]  rsp_msg_length;
   logic [7:0]  rsp_data_byte;
   logic        rsp_data_final;
   logic [31:0] rsp_crc_error_count;
   logic [31:0] rsp_parse_error_count;
   logic        csr_write_enable;
   logic [2:0]  csr_write_data;

   fragment_reassembler_crc16 dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_frag_byte         (req_frag_byte),
      .req_frag_last         (req_frag_last),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_msg_type          (rsp_msg_type),
      .rsp_msg_ident         (rsp_msg_ident),
      .rsp_msg_length        (rsp_msg_length),
      .rsp_data_byte         (rsp_data_byte),
      .rsp_data_final        (rsp_data_final),
      .rsp_crc_error_count   (rsp_crc_error_count),
      .rsp_parse_error_count (rsp_parse_error_count),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data)
   );

   always #4 clock = ~clock;

   // Predictor copy of the block state
   logic [2:0]  more_pos_cfg;
   logic [15:0] run_crc;
   logic [7:0]  lag0, lag1;
   int          frame_count;
   logic [15:0] hdr_type;
   logic [7:0]  hdr_flags;
   logic [7:0]  hdr_ident;
   logic [15:0] hdr_plen;
   logic [7:0]  msg_store [MSG_MAX];
   int          msg_len;
   int          next_seq;
   logic        msg_open;
   logic [15:0] open_type;
   logic [7:0]  open_ident;
   logic [31:0] crc_err_total;
   logic [31:0] parse_err_total;

   beat_type         pending_beats [$];
   status_type       table_by_frag [int];
   logic             table_armed;
   status_type       table_status;
   int               frags_sent;
   int               frags_done;
   int               sent_bytes;
   int               mismatches;
   int               quiet_cycles;
   logic             steady;

   function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] crc, input logic [7:0] b);
      logic fb;
      for (int k = 7; k >= 0; k--) begin
         fb = crc[15] ^ b[k];
         crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return crc;
   endfunction

   function automatic void clear_model();
      more_pos_cfg = MORE_POS_RESET;
      run_crc = CRC_INIT;
      lag0 = 8'h00;
      lag1 = 8'h00;
      frame_count = 0;
      hdr_type = 16'h0000;
      hdr_flags = 8'h00;
      hdr_ident = 8'h00;
      hdr_plen = 16'h0000;
      foreach (msg_store[i]) msg_store[i] = 8'h00;
      msg_len = 0;
      next_seq = 0;
      msg_open = 1'b0;
      open_type = 16'h0000;
      open_ident = 8'h00;
      crc_err_total = 32'd0;
      parse_err_total = 32'd0;
   endfunction

   function automatic void push_beat(input status_type st, input logic [15:0] t,
                                     input logic [7:0] id, input int n,
                                     input logic [7:0] d, input logic fin);
      beat_type beat;
      beat.status = st;
      beat.msg_type = t;
      beat.msg_ident = id;
      beat.msg_length = 7'(n);
      beat.data_byte = d;
      beat.data_final = fin;
      beat.crc_errs = crc_err_total;
      beat.parse_errs = parse_err_total;
      beat.has_table = table_armed;
      beat.table_status = table_status;
      table_armed = 1'b0;
      pending_beats.push_back(beat);
   endfunction

   // Advance the predictor by one accepted byte and queue the beats it causes
   function automatic void reassemble_byte(input logic [7:0] b, input logic last);
      int idx, addr, flen;
      logic more;
      status_type st;
      idx = frame_count;
      // crc trails the input by two bytes so the trailer is never absorbed
      if (idx >= 2) run_crc = crc_ccitt_byte(run_crc, lag1);
      lag1 = lag0;
      lag0 = b;
      case (idx)
         0: hdr_type = {b, 8'h00};
         1: hdr_type[7:0] = b;
         2: hdr_flags = b;
         3: hdr_ident = b;
         4: hdr_plen = {b, 8'h00};
         5: hdr_plen[7:0] = b;
         default: ;
      endcase
      // stage payload; continuation fragments land after the open message
      if (idx >= HDR_BYTES && idx < MSG_MAX) begin
         addr = (hdr_flags[3:0] == 4'd0) ? 0 : msg_len;
         addr += idx - HDR_BYTES;
         if (addr < MSG_MAX) msg_store[addr] = b;
      end
      if (idx <= MSG_MAX) frame_count = idx + 1;
      if (!last) return;

      flen = frame_count;
      more = hdr_flags[more_pos_cfg];
      st = STAT_TAKEN;
      if (flen > MSG_MAX || flen < MIN_FRAME) begin
         st = STAT_LEN;
      end else if (run_crc != {lag1, lag0}) begin
         st = STAT_CRC;
      end else if (hdr_plen != 16'(flen - MIN_FRAME)) begin
         st = STAT_LEN;
      end else if (hdr_flags[3:0] == 4'd0) begin
         open_type = hdr_type;
         open_ident = hdr_ident;
         next_seq = 1;
         msg_len = hdr_plen;
         msg_open = 1'b1;
      end else if (msg_open && hdr_flags[3:0] == next_seq && hdr_type == open_type &&
                   hdr_ident == open_ident && hdr_plen <= MSG_MAX - msg_len) begin
         msg_len += hdr_plen;
         if (next_seq < SEQ_LIMIT) next_seq++;
      end else begin
         st = STAT_SEQ;
      end

      run_crc = CRC_INIT;
      lag0 = 8'h00;
      lag1 = 8'h00;
      frame_count = 0;

      // drop the partial message on any error
      if (st == STAT_CRC) begin
         crc_err_total++;
         msg_open = 1'b0;
      end else if (st != STAT_TAKEN) begin
         parse_err_total++;
         msg_open = 1'b0;
      end

      table_armed = table_by_frag.exists(frags_done);
      if (table_armed) table_status = table_by_frag[frags_done];
      frags_done++;

      if (st != STAT_TAKEN || more) begin
         push_beat(st, 16'h0000, 8'h00, 0, 8'h00, 1'b1);
      end else begin
         msg_open = 1'b0;
         if (msg_len == 0) begin
            push_beat(STAT_DONE, open_type, open_ident, 0, 8'h00, 1'b1);
         end else begin
            for (int i = 0; i < msg_len && i < MSG_MAX; i++)
               push_beat(STAT_DONE, open_type, open_ident, msg_len, msg_store[i],
                         i + 1 == msg_len);
         end
      end
   endfunction

   function automatic void check_field(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   // Sample both channels at the edge, predict on input beats, compare output beats
   always @(posedge clock) begin
      beat_type want;
      if (!reset) begin
         if (req_valid && !req_stall) reassemble_byte(req_frag_byte, req_frag_last);
         if (rsp_valid && !rsp_stall) begin
            if (pending_beats.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual status %0d",
                        $time, rsp_status);
               mismatches++;
            end else begin
               want = pending_beats.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("msg_type", want.msg_type, rsp_msg_type);
               check_field("msg_ident", want.msg_ident, rsp_msg_ident);
               check_field("msg_length", want.msg_length, rsp_msg_length);
               check_field("data_byte", want.data_byte, rsp_data_byte);
               check_field("data_final", want.data_final, rsp_data_final);
               check_field("crc_error_count", want.crc_errs, rsp_crc_error_count);
               check_field("parse_error_count", want.parse_errs, rsp_parse_error_count);
               if (want.has_table)
                  check_field("table status", want.table_status, rsp_status);
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stall the result channel at random except during the steady stretch
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 37);
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("fragment_reassembler_crc16 test failed");
      $finish;
   end

   // Present one byte, with random gaps ahead of it, and hold it until taken
   task automatic send_byte(input logic [7:0] b, input logic last);
      while (!steady && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_frag_byte <= b;
      req_frag_last <= last;
      do @(posedge clock); while (req_stall);
      sent_bytes++;
   endtask

   task automatic send_fragment(input logic [15:0] ftype, input logic [7:0] flags,
                                input logic [7:0] ident, input int pay_len,
                                input fault_type fault);
      logic [7:0]  frame [$];
      logic [15:0] crc;
      logic [15:0] plen;
      int          pick;
      crc = CRC_INIT;
      plen = 16'(pay_len);
      if (fault == F_PLEN) plen = plen ^ (16'd1 << $urandom_range(15));
      if (fault == F_NOISE) begin
         for (int i = 0; i < pay_len; i++) frame.push_back(8'($urandom));
      end else begin
         frame.push_back(ftype[15:8]);
         frame.push_back(ftype[7:0]);
         frame.push_back(flags);
         frame.push_back(ident);
         frame.push_back(plen[15:8]);
         frame.push_back(plen[7:0]);
         if (fault != F_SHORT)
            for (int i = 0; i < pay_len; i++) frame.push_back(8'($urandom));
         foreach (frame[i]) crc = crc_ccitt_byte(crc, frame[i]);
         frame.push_back(crc[15:8]);
         frame.push_back(crc[7:0]);
         // flip one bit anywhere; a single-bit error always breaks the crc
         if (fault == F_CRC) begin
            pick = $urandom_range(frame.size() - 1);
            frame[pick] = frame[pick] ^ (8'd1 << $urandom_range(7));
         end
         if (fault == F_SHORT)
            while (frame.size() > pay_len) void'(frame.pop_back());
      end
      frags_sent++;
      foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
   endtask

   // Hold the sender until every expected beat is out and the block has settled
   task automatic await_idle();
      req_valid <= 1'b0;
      // let the predictor see the last accepted byte first
      @(posedge clock);
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_more_pos(input logic [2:0] pos);
      await_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= pos;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      more_pos_cfg = pos;
   endtask

   // Well-formed message with random content, some fragments damaged
   task automatic send_random_message();
      logic [15:0] mtype;
      logic [7:0]  mident;
      logic [7:0]  flags;
      int          nfrag, plen, seq;
      fault_type   fault;
      mtype = 16'($urandom);
      mident = 8'($urandom);
      nfrag = $urandom_range(1, 2);
      for (int f = 0; f < nfrag; f++) begin
         plen = ($urandom_range(7) == 0) ? $urandom_range(20, 58) : $urandom_range(0, 8);
         seq = f;
         fault = F_NONE;
         if ($urandom_range(99) < 25) fault = fault_type'($urandom_range(1, 7));
         case (fault)
            F_SHORT: plen = $urandom_range(1, 7);
            F_NOISE: plen = $urandom_range(1, 24);
            F_SEQ:   seq = $urandom_range(15);
            F_TYPE:  mtype = mtype ^ (16'd1 << $urandom_range(15));
            F_IDENT: mident = mident ^ (8'd1 << $urandom_range(7));
            default: ;
         endcase
         flags = {4'($urandom), 4'(seq)};
         if (more_pos_cfg >= 3'd4) flags[more_pos_cfg] = (f < nfrag - 1);
         send_fragment(mtype, flags, mident, plen, fault);
      end
   endtask

   initial begin
      directed_row_type row;
      int               start;
      reset = 1'b1;
      req_valid = 1'b0;
      req_frag_byte = 8'h00;
      req_frag_last = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = 3'd0;
      steady = 1'b0;
      table_armed = 1'b0;
      table_status = STAT_TAKEN;
      frags_sent = 0;
      frags_done = 0;
      sent_bytes = 0;
      mismatches = 0;
      quiet_cycles = 0;
      clear_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table; the store-filling message never idles
      for (int r = 0; r < NUM_ROWS; r++) begin
         row = DIRECTED_ROWS[r];
         if (row.more_pos != more_pos_cfg) write_more_pos(row.more_pos);
         steady = (r == STEADY_ROW) || (r == STEADY_ROW + 1);
         if (row.checked) table_by_frag[frags_sent] = row.exp_status;
         for (int k = 0; k < row.runs; k++)
            send_fragment(row.ftype, row.flags + 8'(k), row.ident, row.pay_len, row.fault);
      end
      steady = 1'b0;

      // random phases: more bit at the top of the flags, then inside the sequence field
      for (int p = 0; p < 2; p++) begin
         write_more_pos(RANDOM_POSITIONS[p]);
         start = sent_bytes;
         while (sent_bytes - start < PHASE_BYTES) send_random_message();
      end

      await_idle();
      repeat (12) @(posedge clock);
      if (mismatches == 0)
         $display("fragment_reassembler_crc16 test passed");
      else
         $display("fragment_reassembler_crc16 test failed");
      $finish;
   end

endmodule
